// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; nearest_floor_request_queue_unit.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

`endif

// ----- rtl/nfrq_pkg.sv -----
package nfrq_pkg;

   localparam int FLOOR_W            = 4;
   localparam int STATUS_W           = 3;
   localparam int DIR_W              = 2;
   localparam int NUM_FLOORS_DEFAULT = 11;

   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ARRIVED = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd5;

   localparam logic signed [DIR_W-1:0] DIR_IDLE = 2'sd0;
   localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sd1;
   localparam logic signed [DIR_W-1:0] DIR_DOWN = -2'sd1;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_cmd_type;

   function automatic logic [FLOOR_W-1:0] floor_dist(input logic [FLOOR_W-1:0] a,
                                                     input logic [FLOOR_W-1:0] b);
      floor_dist = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/nfrq_cell.sv -----
module nfrq_cell (
   input  logic                          clock,
   input  nfrq_pkg::cell_cmd_type        cmd,
   input  logic                          occupied,
   input  logic [nfrq_pkg::FLOOR_W-1:0]  car_floor,
   input  logic [nfrq_pkg::FLOOR_W-1:0]  new_floor,
   input  logic [nfrq_pkg::FLOOR_W-1:0]  new_dist,
   input  logic [nfrq_pkg::FLOOR_W-1:0]  prev_entry,
   input  logic [nfrq_pkg::FLOOR_W-1:0]  next_entry,
   input  logic                          found_in,
   output logic                          found_out,
   output logic [nfrq_pkg::FLOOR_W-1:0]  entry
);
   import nfrq_pkg::*;

   logic [FLOOR_W-1:0] entry_ff;
   logic [FLOOR_W-1:0] entry_in;
   logic               ge;

   assign ge        = occupied && (floor_dist(entry_ff, car_floor) >= new_dist);
   assign found_out = found_in || ge || !occupied;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (found_in) begin
            entry_in = prev_entry;
         end else if (ge || !occupied) begin
            entry_in = new_floor;
         end
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/nearest_floor_request_queue_unit.sv -----
// Channel   | Ports                                                      | Handshake
// ----------+------------------------------------------------------------+-------------------
// request   | req_op, req_floor                                          | start && !busy
// response  | rsp_status, rsp_car_floor, rsp_car_direction, rsp_last     | rsp_strobe
//
// An add transaction gives its single response in the cycle after it is accepted.
// A serve transaction pops the queue in its accept cycle and then steps the car one
// floor per cycle, so it gives one response per floor travelled, at most NUM_FLOORS - 1,
// and keeps busy high while the car moves. When the car is already at the head floor,
// or the queue is empty, it gives one response in the next cycle and busy stays low.
// Reset is synchronous and empties the queue; the car returns to floor zero, idle.
// The receiver cannot stall: each response is shown for exactly one cycle.
`include "assert_macros.svh"

module nearest_floor_request_queue_unit #(
   parameter int NUM_FLOORS = nfrq_pkg::NUM_FLOORS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_op,
   input  logic [nfrq_pkg::FLOOR_W-1:0]         req_floor,
   output logic                                 rsp_strobe,
   output logic [nfrq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [nfrq_pkg::FLOOR_W-1:0]         rsp_car_floor,
   output logic signed [nfrq_pkg::DIR_W-1:0]    rsp_car_direction,
   output logic                                 rsp_last
);
   import nfrq_pkg::*;

   localparam int IDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
   localparam int CNT_W = $clog2(NUM_FLOORS + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_STEP = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [NUM_FLOORS-1:0]    pending_ff, pending_in;
   logic [FLOOR_W-1:0]       car_floor_ff, car_floor_in;
   logic signed [DIR_W-1:0]  direction_ff, direction_in;
   logic [FLOOR_W-1:0]       target_ff, target_in;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [FLOOR_W-1:0]       rsp_floor_ff, rsp_floor_in;
   logic signed [DIR_W-1:0]  rsp_dir_ff, rsp_dir_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     floor_ok;
   logic                     is_dup;
   logic [IDX_W-1:0]         req_idx;
   logic [IDX_W-1:0]         head_idx;
   logic [FLOOR_W-1:0]       new_dist;
   logic [FLOOR_W-1:0]       head;
   logic                     going_up;
   logic [FLOOR_W-1:0]       step_floor;
   logic signed [DIR_W-1:0]  step_dir;
   cell_cmd_type             cmd;

   logic [FLOOR_W-1:0]       entry [NUM_FLOORS];
   logic [NUM_FLOORS:0]      found;
   logic [NUM_FLOORS-1:0]    occupied;

   assign busy     = (state_ff == S_STEP);
   assign accept   = start && !busy;
   assign floor_ok = {1'b0, req_floor} < (FLOOR_W + 1)'(NUM_FLOORS);
   assign req_idx  = req_floor[IDX_W-1:0];
   assign is_dup   = pending_ff[req_idx] || (count_ff >= CNT_W'(NUM_FLOORS));
   assign new_dist = floor_dist(req_floor, car_floor_ff);
   assign head     = entry[0];
   assign head_idx = head[IDX_W-1:0];

   assign going_up   = target_ff > car_floor_ff;
   assign step_floor = going_up ? (car_floor_ff + FLOOR_W'(1)) : (car_floor_ff - FLOOR_W'(1));
   assign step_dir   = going_up ? DIR_UP : DIR_DOWN;

   assign cmd.insert = accept && !req_op && floor_ok && !is_dup;
   assign cmd.pop    = accept && req_op && (count_ff != '0);

   assign found[0] = 1'b0;

   for (genvar i = 0; i < NUM_FLOORS; i++) begin : g_cell
      logic [FLOOR_W-1:0] prev_entry;
      logic [FLOOR_W-1:0] next_entry;

      assign occupied[i] = count_ff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign prev_entry = req_floor;
      end else begin : g_inner_prev
         assign prev_entry = entry[i-1];
      end

      if (i == NUM_FLOORS - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_inner_next
         assign next_entry = entry[i+1];
      end

      nfrq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied[i]),
         .car_floor  (car_floor_ff),
         .new_floor  (req_floor),
         .new_dist   (new_dist),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .entry      (entry[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      car_floor_in  = car_floor_ff;
      direction_in  = direction_ff;
      target_in     = target_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_floor_in  = rsp_floor_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_op) begin
                  rsp_strobe_in = 1'b1;
                  rsp_floor_in  = car_floor_ff;
                  rsp_dir_in    = direction_ff;
                  rsp_last_in   = 1'b1;
                  if (!floor_ok) begin
                     rsp_status_in = STATUS_INVALID;
                  end else if (is_dup) begin
                     rsp_status_in = STATUS_DUP;
                  end else begin
                     rsp_status_in        = STATUS_ADDED;
                     count_in             = count_ff + CNT_W'(1);
                     pending_in[req_idx]  = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  direction_in  = DIR_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_floor_in  = car_floor_ff;
                  rsp_dir_in    = DIR_IDLE;
                  rsp_last_in   = 1'b1;
               end else begin
                  count_in             = count_ff - CNT_W'(1);
                  pending_in[head_idx] = 1'b0;
                  target_in            = head;
                  if (head == car_floor_ff) begin
                     if (count_ff == CNT_W'(1)) begin
                        direction_in = DIR_IDLE;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_ARRIVED;
                     rsp_floor_in  = car_floor_ff;
                     rsp_dir_in    = (count_ff == CNT_W'(1)) ? DIR_IDLE : direction_ff;
                     rsp_last_in   = 1'b1;
                  end else begin
                     state_in = S_STEP;
                  end
               end
            end
         end
         S_STEP: begin
            car_floor_in  = step_floor;
            rsp_strobe_in = 1'b1;
            rsp_floor_in  = step_floor;
            if (step_floor != target_ff) begin
               direction_in  = step_dir;
               rsp_status_in = STATUS_MOVED;
               rsp_dir_in    = step_dir;
               rsp_last_in   = 1'b0;
            end else begin
               direction_in  = (count_ff == '0) ? DIR_IDLE : step_dir;
               rsp_status_in = STATUS_ARRIVED;
               rsp_dir_in    = (count_ff == '0) ? DIR_IDLE : step_dir;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pending_ff    <= '0;
         car_floor_ff  <= '0;
         direction_ff  <= DIR_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         car_floor_ff  <= car_floor_in;
         direction_ff  <= direction_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      rsp_status_ff <= rsp_status_in;
      rsp_floor_ff  <= rsp_floor_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_car_floor     = rsp_floor_ff;
   assign rsp_car_direction = rsp_dir_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_ALWAYS(a_pending_matches_count, clock, reset, $countones(pending_ff) == count_ff)
   `ASSERT_IMPLIES(a_step_not_arrived, clock, reset, busy, target_ff != car_floor_ff)
   `ASSERT_IMPLIES(a_moved_keeps_busy, clock, reset, rsp_strobe_ff && !rsp_last_ff, busy)

endmodule
